// ===== hw/rtl/u8sv_pkg.sv =====
// Package with the constants and the code point check of the UTF-8 stream validator.
`timescale 1ns / 1ps

package u8sv_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo      = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CpW-1:0] NonCharLo   = 21'h00FDD0;
  localparam logic [CpW-1:0] NonCharHi   = 21'h00FDEF;
  localparam logic [15:0]    PlaneEndPat = 16'hFFFE;
  localparam logic [CpW-1:0] Min2Byte    = 21'h000080;
  localparam logic [CpW-1:0] Min3Byte    = 21'h000800;
  localparam logic [CpW-1:0] Min4Byte    = 21'h010000;

  // Continuation counts of a sequence, as held in the sequence length register.
  localparam logic [1:0] SeqLen2 = 2'd1;
  localparam logic [1:0] SeqLen3 = 2'd2;
  localparam logic [1:0] SeqLen4 = 2'd3;

  // True when a completed code point is not overlong, not above 10FFFF, no surrogate and no noncharacter.
  function automatic logic cp_ok(logic [CpW-1:0] cp, logic [1:0] seq_len);
    logic ok;
    ok = 1'b1;
    if (seq_len == SeqLen2 && cp < Min2Byte) ok = 1'b0;
    if (seq_len == SeqLen3 && cp < Min3Byte) ok = 1'b0;
    if (seq_len == SeqLen4 && cp < Min4Byte) ok = 1'b0;
    if (cp > CpMax) ok = 1'b0;
    if (cp >= SurrLo && cp <= SurrHi) ok = 1'b0;
    if (cp >= NonCharLo && cp <= NonCharHi) ok = 1'b0;
    if ((cp[15:0] & PlaneEndPat) == PlaneEndPat) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ===== hw/rtl/utf8_stream_validator_unit.sv =====
// Top level of the UTF-8 stream validator: byte decoder, message state and result register.
`timescale 1ns / 1ps

// Checks a message for well-formed UTF-8, one byte per beat, one beat per clock
// unless stalled. Each accepted byte updates the decoder state in the same cycle;
// the beat that carries the final byte loads the verdict into the output register,
// which shows it from the next cycle on. The input is stalled only while that
// register holds a verdict that the receiver is stalling, so a new message may
// begin in the cycle right after a final byte. A NUL lead byte passes the message
// and the decoder ignores the rest of it; after a failure the rest is ignored too.
module utf8_stream_validator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_valid_o
);

  logic [1:0]                 pend_q, pend_d;
  logic [1:0]                 seq_q, seq_d;
  logic [u8sv_pkg::CpW-1:0]   acc_q, acc_d;
  logic                       fail_q, fail_d;
  logic                       stop_q, stop_d;
  logic                       out_valid_q, out_valid_d;
  logic                       is_valid_q, is_valid_d;
  logic                       in_acc;

  logic [1:0]                 pend_t, seq_t;
  logic [u8sv_pkg::CpW-1:0]   acc_t, cp_t;
  logic                       fail_t, stop_t;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign is_valid_o  = is_valid_q;

  assign cp_t = {acc_q[u8sv_pkg::CpW-7:0], data_byte_i[5:0]};

  // Decoder step for one byte.
  always_comb begin
    pend_t = pend_q;
    seq_t  = seq_q;
    acc_t  = acc_q;
    fail_t = fail_q;
    stop_t = stop_q;
    if (!fail_q && !stop_q) begin
      if (pend_q == 2'd0) begin
        if (data_byte_i == 8'h00) begin
          stop_t = 1'b1;
        end else if (!data_byte_i[7]) begin
          // Plain ASCII leaves the state as it is.
        end else if (data_byte_i[7:5] == 3'b110) begin
          if (data_byte_i[4:0] == 5'd0) begin
            fail_t = 1'b1;
          end else begin
            acc_t  = {16'd0, data_byte_i[4:0]};
            pend_t = u8sv_pkg::SeqLen2;
            seq_t  = u8sv_pkg::SeqLen2;
          end
        end else if (data_byte_i[7:4] == 4'b1110) begin
          acc_t  = {17'd0, data_byte_i[3:0]};
          pend_t = u8sv_pkg::SeqLen3;
          seq_t  = u8sv_pkg::SeqLen3;
        end else if (data_byte_i[7:3] == 5'b11110) begin
          acc_t  = {18'd0, data_byte_i[2:0]};
          pend_t = u8sv_pkg::SeqLen4;
          seq_t  = u8sv_pkg::SeqLen4;
        end else begin
          fail_t = 1'b1;
        end
      end else if (data_byte_i[7:6] != 2'b10) begin
        fail_t = 1'b1;
      end else begin
        acc_t  = cp_t;
        pend_t = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          if (!u8sv_pkg::cp_ok(cp_t, seq_q)) fail_t = 1'b1;
          seq_t = 2'd0;
          acc_t = '0;
        end
      end
    end
  end

  always_comb begin
    pend_d      = pend_q;
    seq_d       = seq_q;
    acc_d       = acc_q;
    fail_d      = fail_q;
    stop_d      = stop_q;
    is_valid_d  = is_valid_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (in_acc) begin
      if (last_byte_i) begin
        // A sequence still open at the final byte fails the message.
        is_valid_d  = ~fail_t & (stop_t | (pend_t == 2'd0));
        out_valid_d = 1'b1;
        pend_d      = 2'd0;
        seq_d       = 2'd0;
        acc_d       = '0;
        fail_d      = 1'b0;
        stop_d      = 1'b0;
      end else begin
        pend_d = pend_t;
        seq_d  = seq_t;
        acc_d  = acc_t;
        fail_d = fail_t;
        stop_d = stop_t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 2'd0;
      seq_q       <= 2'd0;
      acc_q       <= '0;
      fail_q      <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      seq_q       <= seq_d;
      acc_q       <= acc_d;
      fail_q      <= fail_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_valid_q <= is_valid_d;
  end

endmodule

// ===== hw/rtl/u8sv_checker.sv =====
// Port-level checker for the UTF-8 stream validator, bound to its top level.
`timescale 1ns / 1ps

module u8sv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       is_valid_o
);

  // A verdict held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_valid_o))
    else $error("verdict changed or vanished while stalled");

  // The input is stalled exactly when a verdict waits and is stalled.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow the output register");

  // Every final byte taken gives a verdict in the next cycle.
  a_last_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_byte_i |=> out_valid_o)
    else $error("final byte gave no verdict");

  // A fresh verdict only follows a final byte taken in the cycle before.
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o && out_stall_i)
      |-> $past(in_valid_i && !in_stall_o && last_byte_i))
    else $error("verdict without a final byte");

endmodule

bind utf8_stream_validator_unit u8sv_checker u_u8sv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .last_byte_i (last_byte_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .is_valid_o  (is_valid_o)
);
